>>> rtl/owm_pkg.sv
// ----------------------------------------------------------------------------
// owm_pkg
// Shared types and codes of the 1-Wire bus master: command codes,
// register indexes, the register set and the per-tick result.
// ----------------------------------------------------------------------------
`default_nettype none

package owm_pkg;

    // command codes carried by each tick
    localparam logic [1:0] MODE_TICK  = 2'd0;
    localparam logic [1:0] MODE_RESET = 2'd1;
    localparam logic [1:0] MODE_WRITE = 2'd2;
    localparam logic [1:0] MODE_READ  = 2'd3;

    // register indexes
    localparam logic [2:0] REG_RESET_LOW    = 3'd0;
    localparam logic [2:0] REG_RESET_REL    = 3'd1;
    localparam logic [2:0] REG_PRES_WAIT    = 3'd2;
    localparam logic [2:0] REG_PRES_LOW_MAX = 3'd3;
    localparam logic [2:0] REG_WR1_LOW      = 3'd4;
    localparam logic [2:0] REG_WR0_LOW      = 3'd5;
    localparam logic [2:0] REG_RD_LOW       = 3'd6;
    localparam logic [2:0] REG_RD_RECOVER   = 3'd7;

    localparam int CFG_DATA_W = 10;

    // register reset values
    localparam logic [9:0] RST_RESET_LOW    = 10'd750;
    localparam logic [7:0] RST_RESET_REL    = 8'd15;
    localparam logic [7:0] RST_PRES_WAIT    = 8'd100;
    localparam logic [8:0] RST_PRES_LOW_MAX = 9'd240;
    localparam logic [5:0] RST_WR1_LOW      = 6'd5;
    localparam logic [6:0] RST_WR0_LOW      = 7'd70;
    localparam logic [5:0] RST_RD_LOW       = 6'd10;
    localparam logic [6:0] RST_RD_RECOVER   = 7'd45;

    // fixed release times after a write slot's low
    localparam logic [9:0] WR1_HIGH_US    = 10'd65;
    localparam logic [9:0] WR0_RECOVER_US = 10'd2;

    typedef struct packed {
        logic [9:0] reset_low_us;
        logic [7:0] reset_release_us;
        logic [7:0] presence_wait_us;
        logic [8:0] presence_low_max_us;
        logic [5:0] write_one_low_us;
        logic [6:0] write_zero_low_us;
        logic [5:0] read_low_us;
        logic [6:0] read_recover_us;
    } cfg_t;

    typedef struct packed {
        logic       drive_low;
        logic       busy;
        logic       done;
        logic       presence_fail;
        logic [7:0] rx_byte;
    } result_t;

endpackage

`default_nettype wire

>>> rtl/owm_core.sv
// ----------------------------------------------------------------------------
// owm_core
// Bit-slot sequencer: phase, tick counter and shift registers. Works out the
// result of the current tick and the next state in one pass.
// ----------------------------------------------------------------------------
`default_nettype none

module owm_core
    import owm_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       step,
    input  wire logic [1:0] mode,
    input  wire logic [7:0] tx_byte,
    input  wire logic       line_level,
    input  wire cfg_t       cfg,
    output result_t         res
);

    localparam logic [3:0] PH_IDLE      = 4'd0;
    localparam logic [3:0] PH_RST_LOW   = 4'd1;
    localparam logic [3:0] PH_RST_REL   = 4'd2;
    localparam logic [3:0] PH_PRES_WAIT = 4'd3;
    localparam logic [3:0] PH_PRES_LOW  = 4'd4;
    localparam logic [3:0] PH_WR_LOW    = 4'd5;
    localparam logic [3:0] PH_WR_HIGH   = 4'd6;
    localparam logic [3:0] PH_RD_LOW    = 4'd7;
    localparam logic [3:0] PH_RD_SAMPLE = 4'd8;
    localparam logic [3:0] PH_RD_REC    = 4'd9;

    logic [3:0] phase_reg, phase_next;
    logic [9:0] tick_reg, tick_next;
    logic [2:0] bit_reg, bit_next;
    logic [7:0] sout_reg, sout_next;
    logic [7:0] sin_reg, sin_next;
    logic       fail_reg, fail_next;
    logic [9:0] bumped;
    logic       finish;

    // a zero duration still lasts one tick
    function automatic logic [9:0] span(input logic [9:0] d);
        return (d == 10'd0) ? 10'd1 : d;
    endfunction

    always_comb
    begin
        phase_next = phase_reg;
        tick_next  = tick_reg;
        bit_next   = bit_reg;
        sout_next  = sout_reg;
        sin_next   = sin_reg;
        fail_next  = fail_reg;
        res        = '0;
        finish     = 1'b0;

        // a command starts on the tick that carries it
        if (phase_reg == PH_IDLE && mode != MODE_TICK)
        begin
            tick_next = '0;
            bit_next  = '0;
            fail_next = 1'b0;
            case (mode)
                MODE_RESET: phase_next = PH_RST_LOW;
                MODE_WRITE:
                begin
                    sout_next  = tx_byte;
                    phase_next = PH_WR_LOW;
                end
                default:
                begin
                    sin_next   = '0;
                    phase_next = PH_RD_LOW;
                end
            endcase
        end

        bumped = tick_next + 10'd1;

        if (phase_next != PH_IDLE)
        begin
            res.busy = 1'b1;
            case (phase_next)
                PH_RST_LOW:
                begin
                    res.drive_low = 1'b1;
                    tick_next     = bumped;
                    if (bumped >= span(cfg.reset_low_us))
                    begin
                        tick_next  = '0;
                        phase_next = (cfg.reset_release_us != 8'd0) ? PH_RST_REL
                                                                    : PH_PRES_WAIT;
                    end
                end
                PH_RST_REL:
                begin
                    tick_next = bumped;
                    if (bumped >= {2'b00, cfg.reset_release_us})
                    begin
                        tick_next  = '0;
                        phase_next = PH_PRES_WAIT;
                    end
                end
                PH_PRES_WAIT:
                begin
                    if (cfg.presence_wait_us == 8'd0)
                    begin
                        fail_next = 1'b1;
                        finish    = 1'b1;
                    end
                    else if (line_level)
                    begin
                        tick_next = bumped;
                        if (bumped >= {2'b00, cfg.presence_wait_us})
                        begin
                            fail_next = 1'b1;
                            finish    = 1'b1;
                        end
                    end
                    else
                    begin
                        // this low tick is the first of the presence pulse
                        tick_next = 10'd1;
                        if (cfg.presence_low_max_us <= 9'd1)
                        begin
                            fail_next = 1'b1;
                            finish    = 1'b1;
                        end
                        else
                        begin
                            phase_next = PH_PRES_LOW;
                        end
                    end
                end
                PH_PRES_LOW:
                begin
                    if (line_level)
                    begin
                        finish = 1'b1;
                    end
                    else
                    begin
                        tick_next = bumped;
                        if (bumped >= {1'b0, cfg.presence_low_max_us})
                        begin
                            fail_next = 1'b1;
                            finish    = 1'b1;
                        end
                    end
                end
                PH_WR_LOW:
                begin
                    res.drive_low = 1'b1;
                    tick_next     = bumped;
                    if (bumped >= span(sout_next[0] ? {4'd0, cfg.write_one_low_us}
                                                    : {3'd0, cfg.write_zero_low_us}))
                    begin
                        tick_next  = '0;
                        phase_next = PH_WR_HIGH;
                    end
                end
                PH_WR_HIGH:
                begin
                    tick_next = bumped;
                    if (bumped >= (sout_next[0] ? WR1_HIGH_US : WR0_RECOVER_US))
                    begin
                        tick_next = '0;
                        if (bit_next == 3'd7)
                        begin
                            finish = 1'b1;
                        end
                        else
                        begin
                            bit_next   = bit_next + 3'd1;
                            sout_next  = {1'b0, sout_next[7:1]};
                            phase_next = PH_WR_LOW;
                        end
                    end
                end
                PH_RD_LOW:
                begin
                    res.drive_low = 1'b1;
                    tick_next     = bumped;
                    if (bumped >= span({4'd0, cfg.read_low_us}))
                    begin
                        tick_next  = '0;
                        phase_next = PH_RD_SAMPLE;
                    end
                end
                PH_RD_SAMPLE:
                begin
                    sin_next[bit_next] = sin_next[bit_next] | line_level;
                    tick_next          = '0;
                    phase_next         = PH_RD_REC;
                end
                PH_RD_REC:
                begin
                    tick_next = bumped;
                    if (bumped >= span({3'd0, cfg.read_recover_us}))
                    begin
                        tick_next = '0;
                        if (bit_next == 3'd7)
                        begin
                            res.rx_byte = sin_next;
                            finish      = 1'b1;
                        end
                        else
                        begin
                            bit_next   = bit_next + 3'd1;
                            phase_next = PH_RD_LOW;
                        end
                    end
                end
                default:
                begin
                    phase_next = PH_IDLE;
                    tick_next  = '0;
                end
            endcase

            if (finish)
            begin
                res.done          = 1'b1;
                res.presence_fail = fail_next;
                phase_next        = PH_IDLE;
                tick_next         = '0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_IDLE;
            tick_reg  <= '0;
            bit_reg   <= '0;
            sout_reg  <= '0;
            sin_reg   <= '0;
            fail_reg  <= 1'b0;
        end
        else if (step)
        begin
            phase_reg <= phase_next;
            tick_reg  <= tick_next;
            bit_reg   <= bit_next;
            sout_reg  <= sout_next;
            sin_reg   <= sin_next;
            fail_reg  <= fail_next;
        end
    end

endmodule

`default_nettype wire

>>> rtl/one_wire_bus_master.sv
// ----------------------------------------------------------------------------
// one_wire_bus_master
// 1-Wire master timed by microsecond ticks: reset/presence, byte write and
// byte read slots, with a register set for the slot timings.
// ----------------------------------------------------------------------------
// Usage:
//   Feed one item per microsecond on the input channel (in_valid/in_stall):
//   mode, tx_byte and the sampled line_level. Each accepted item yields
//   exactly one result item on the output channel (out_valid/out_stall):
//   drive_low for that tick plus busy/done/presence_fail/rx_byte status.
//   A command acts on the tick that carries it; commands while busy are
//   ignored.
//   Throughput is one item per cycle while in_stall is low; each result
//   is presented from the output register.
//   A two-entry output stage (output register plus skid register) keeps
//   the input open for one more item while a result is stalled; in_stall
//   rises only once both entries are full.
//   Timing registers are written through cfg_we/cfg_index/cfg_data; the user
//   writes them only while the block is idle, which the block does not enforce.
//   Reset (rst_n low) returns the sequencer to idle, empties the output
//   stage and loads the default timings (750/15/100/240/5/70/10/45 us).
// ----------------------------------------------------------------------------
`default_nettype none

module one_wire_bus_master
    import owm_pkg::*;
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    // input channel
    input  wire logic                  in_valid,
    output logic                       in_stall,
    input  wire logic [1:0]            mode,
    input  wire logic [7:0]            tx_byte,
    input  wire logic                  line_level,
    // output channel
    output logic                       out_valid,
    input  wire logic                  out_stall,
    output logic                       drive_low,
    output logic                       busy_res,
    output logic                       done_res,
    output logic                       presence_fail,
    output logic [7:0]                 rx_byte,
    // configuration
    input  wire logic                  cfg_we,
    input  wire logic [2:0]            cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_data
);

    cfg_t    cfg_reg;
    result_t step_res;
    result_t out_reg;
    result_t skid_reg;
    logic    out_valid_reg;
    logic    skid_valid_reg;
    logic    in_fire;
    logic    out_fire;

    assign in_stall = skid_valid_reg;
    assign in_fire  = in_valid && !skid_valid_reg;
    assign out_fire = out_valid_reg && !out_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.reset_low_us        <= RST_RESET_LOW;
            cfg_reg.reset_release_us    <= RST_RESET_REL;
            cfg_reg.presence_wait_us    <= RST_PRES_WAIT;
            cfg_reg.presence_low_max_us <= RST_PRES_LOW_MAX;
            cfg_reg.write_one_low_us    <= RST_WR1_LOW;
            cfg_reg.write_zero_low_us   <= RST_WR0_LOW;
            cfg_reg.read_low_us         <= RST_RD_LOW;
            cfg_reg.read_recover_us     <= RST_RD_RECOVER;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_RESET_LOW:    cfg_reg.reset_low_us        <= cfg_data[9:0];
                REG_RESET_REL:    cfg_reg.reset_release_us    <= cfg_data[7:0];
                REG_PRES_WAIT:    cfg_reg.presence_wait_us    <= cfg_data[7:0];
                REG_PRES_LOW_MAX: cfg_reg.presence_low_max_us <= cfg_data[8:0];
                REG_WR1_LOW:      cfg_reg.write_one_low_us    <= cfg_data[5:0];
                REG_WR0_LOW:      cfg_reg.write_zero_low_us   <= cfg_data[6:0];
                REG_RD_LOW:       cfg_reg.read_low_us         <= cfg_data[5:0];
                REG_RD_RECOVER:   cfg_reg.read_recover_us     <= cfg_data[6:0];
                default:          cfg_reg                     <= cfg_reg;
            endcase
        end
    end

    owm_core u_core
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .step       (in_fire),
        .mode       (mode),
        .tx_byte    (tx_byte),
        .line_level (line_level),
        .cfg        (cfg_reg),
        .res        (step_res)
    );

    // output register with skid entry
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (out_fire || !out_valid_reg)
        begin
            if (skid_valid_reg)
            begin
                out_valid_reg  <= 1'b1;
                skid_valid_reg <= 1'b0;
            end
            else
            begin
                out_valid_reg <= in_fire;
            end
        end
        else if (in_fire)
        begin
            skid_valid_reg <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_fire || !out_valid_reg)
        begin
            if (skid_valid_reg)
            begin
                out_reg <= skid_reg;
            end
            else if (in_fire)
            begin
                out_reg <= step_res;
            end
        end
        else if (in_fire)
        begin
            skid_reg <= step_res;
        end
    end

    assign out_valid     = out_valid_reg;
    assign drive_low     = out_reg.drive_low;
    assign busy_res      = out_reg.busy;
    assign done_res      = out_reg.done;
    assign presence_fail = out_reg.presence_fail;
    assign rx_byte       = out_reg.rx_byte;

`ifndef SYNTH
    a_skid_implies_out: assert property (@(posedge clk) disable iff (!rst_n)
        skid_valid_reg |-> out_valid_reg)
        else $error("skid entry full while output register empty");

    a_skid_fill_on_stall: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(skid_valid_reg) |-> $past(out_valid_reg && out_stall))
        else $error("skid entry filled without a stalled output");

    a_done_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_reg.done) |-> out_reg.busy)
        else $error("done without busy");

    a_fail_on_done: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_reg.presence_fail) |-> out_reg.done)
        else $error("presence_fail outside command completion");

    a_drive_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_reg.drive_low) |-> (out_reg.busy && !out_reg.done))
        else $error("line driven low outside a command slot");
`endif

endmodule

`default_nettype wire

>>> dv/owm_checker.sv
// ----------------------------------------------------------------------------
// owm_checker
// Watches both channels and the register port of the 1-Wire bus master. It
// runs its own slot sequencer on every accepted tick and compares each
// result item, field by field, with the oldest prediction still waiting.
// ----------------------------------------------------------------------------
`default_nettype none

module owm_checker
    import owm_pkg::*;
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  in_valid,
    input  wire logic                  in_stall,
    input  wire logic [1:0]            mode,
    input  wire logic [7:0]            tx_byte,
    input  wire logic                  line_level,
    input  wire logic                  out_valid,
    input  wire logic                  out_stall,
    input  wire logic                  drive_low,
    input  wire logic                  busy_res,
    input  wire logic                  done_res,
    input  wire logic                  presence_fail,
    input  wire logic [7:0]            rx_byte,
    input  wire logic                  cfg_we,
    input  wire logic [2:0]            cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_data,
    output int                         mismatches,
    output int                         outstanding,
    output bit                         seq_active,
    output int                         results_checked,
    output int                         presence_seen,
    output int                         presence_failed,
    output int                         bytes_written,
    output int                         bytes_read
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef enum logic [3:0] {
        SEQ_IDLE, SEQ_RST_LOW, SEQ_RST_REL, SEQ_PRES_WAIT, SEQ_PRES_LOW,
        SEQ_WR_LOW, SEQ_WR_HIGH, SEQ_RD_LOW, SEQ_RD_SAMPLE, SEQ_RD_REC
    } seq_state_t;

    seq_state_t seq;
    logic [9:0] slot_ticks;
    logic [2:0] bit_no;
    logic [7:0] tx_shift;
    logic [7:0] rx_shift;
    logic       fail_seen;
    logic [1:0] cmd_kind;
    cfg_t       timing;
    result_t    expected_ticks[$];

    function automatic logic [9:0] at_least_one(logic [9:0] d);
        return (d == 10'd0) ? 10'd1 : d;
    endfunction

    // one tick of the slot sequencer
    function automatic result_t next_result(logic [1:0] m, logic [7:0] tx, logic ln);
        result_t    r;
        logic       fin;
        logic [9:0] lim;
        r = '0;
        fin = 1'b0;
        if (seq == SEQ_IDLE && m != MODE_TICK)
        begin
            slot_ticks = '0;
            bit_no = '0;
            fail_seen = 1'b0;
            cmd_kind = m;
            case (m)
                MODE_RESET: seq = SEQ_RST_LOW;
                MODE_WRITE:
                begin
                    tx_shift = tx;
                    seq = SEQ_WR_LOW;
                end
                default:
                begin
                    rx_shift = '0;
                    seq = SEQ_RD_LOW;
                end
            endcase
        end
        if (seq != SEQ_IDLE)
        begin
            r.busy = 1'b1;
            case (seq)
                SEQ_RST_LOW:
                begin
                    r.drive_low = 1'b1;
                    slot_ticks++;
                    if (slot_ticks >= at_least_one(timing.reset_low_us))
                    begin
                        slot_ticks = '0;
                        seq = (timing.reset_release_us != 0) ? SEQ_RST_REL : SEQ_PRES_WAIT;
                    end
                end
                SEQ_RST_REL:
                begin
                    slot_ticks++;
                    if (slot_ticks >= timing.reset_release_us)
                    begin
                        slot_ticks = '0;
                        seq = SEQ_PRES_WAIT;
                    end
                end
                SEQ_PRES_WAIT:
                begin
                    if (timing.presence_wait_us == 0)
                    begin
                        fail_seen = 1'b1;
                        fin = 1'b1;
                    end
                    else if (ln)
                    begin
                        slot_ticks++;
                        if (slot_ticks >= timing.presence_wait_us)
                        begin
                            fail_seen = 1'b1;
                            fin = 1'b1;
                        end
                    end
                    else
                    begin
                        // the first low tick already counts towards the limit
                        slot_ticks = 10'd1;
                        if (slot_ticks >= timing.presence_low_max_us)
                        begin
                            fail_seen = 1'b1;
                            fin = 1'b1;
                        end
                        else
                            seq = SEQ_PRES_LOW;
                    end
                end
                SEQ_PRES_LOW:
                begin
                    if (ln)
                        fin = 1'b1;
                    else
                    begin
                        slot_ticks++;
                        if (slot_ticks >= timing.presence_low_max_us)
                        begin
                            fail_seen = 1'b1;
                            fin = 1'b1;
                        end
                    end
                end
                SEQ_WR_LOW:
                begin
                    r.drive_low = 1'b1;
                    slot_ticks++;
                    lim = tx_shift[0] ? at_least_one({4'd0, timing.write_one_low_us})
                                      : at_least_one({3'd0, timing.write_zero_low_us});
                    if (slot_ticks >= lim)
                    begin
                        slot_ticks = '0;
                        seq = SEQ_WR_HIGH;
                    end
                end
                SEQ_WR_HIGH:
                begin
                    slot_ticks++;
                    lim = tx_shift[0] ? WR1_HIGH_US : WR0_RECOVER_US;
                    if (slot_ticks >= lim)
                    begin
                        slot_ticks = '0;
                        if (bit_no == 3'd7)
                            fin = 1'b1;
                        else
                        begin
                            bit_no++;
                            tx_shift = tx_shift >> 1;
                            seq = SEQ_WR_LOW;
                        end
                    end
                end
                SEQ_RD_LOW:
                begin
                    r.drive_low = 1'b1;
                    slot_ticks++;
                    if (slot_ticks >= at_least_one({4'd0, timing.read_low_us}))
                    begin
                        slot_ticks = '0;
                        seq = SEQ_RD_SAMPLE;
                    end
                end
                SEQ_RD_SAMPLE:
                begin
                    rx_shift[bit_no] = ln;
                    slot_ticks = '0;
                    seq = SEQ_RD_REC;
                end
                SEQ_RD_REC:
                begin
                    slot_ticks++;
                    if (slot_ticks >= at_least_one({3'd0, timing.read_recover_us}))
                    begin
                        slot_ticks = '0;
                        if (bit_no == 3'd7)
                        begin
                            r.rx_byte = rx_shift;
                            fin = 1'b1;
                        end
                        else
                        begin
                            bit_no++;
                            seq = SEQ_RD_LOW;
                        end
                    end
                end
                default:
                begin
                    seq = SEQ_IDLE;
                    slot_ticks = '0;
                end
            endcase
            if (fin)
            begin
                r.done = 1'b1;
                r.presence_fail = fail_seen;
                seq = SEQ_IDLE;
                slot_ticks = '0;
                case (cmd_kind)
                    MODE_RESET:
                    begin
                        if (fail_seen)
                            presence_failed++;
                        else
                            presence_seen++;
                    end
                    MODE_WRITE: bytes_written++;
                    default:    bytes_read++;
                endcase
            end
        end
        return r;
    endfunction

    task automatic check_field(input string name, input int unsigned want,
                               input int unsigned got);
        if (want != got)
        begin
            $display("%0t: %s mismatch: expected %0h, actual %0h", $time, name, want, got);
            mismatches++;
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        result_t exp_res;
        if (!rst_n)
        begin
            seq = SEQ_IDLE;
            slot_ticks = '0;
            bit_no = '0;
            tx_shift = '0;
            rx_shift = '0;
            fail_seen = 1'b0;
            cmd_kind = MODE_TICK;
            timing = '{RST_RESET_LOW, RST_RESET_REL, RST_PRES_WAIT, RST_PRES_LOW_MAX,
                       RST_WR1_LOW, RST_WR0_LOW, RST_RD_LOW, RST_RD_RECOVER};
            expected_ticks.delete();
            mismatches = 0;
            results_checked = 0;
            presence_seen = 0;
            presence_failed = 0;
            bytes_written = 0;
            bytes_read = 0;
            outstanding <= 0;
            seq_active <= 1'b0;
        end
        else
        begin
            if (out_valid && !out_stall)
            begin
                if (expected_ticks.size() == 0)
                begin
                    $display("%0t: result item with none expected: expected nothing, actual %0h",
                             $time, {drive_low, busy_res, done_res, presence_fail, rx_byte});
                    mismatches++;
                end
                else
                begin
                    exp_res = expected_ticks.pop_front();
                    check_field("drive_low", 32'(exp_res.drive_low), 32'(drive_low));
                    check_field("busy_res", 32'(exp_res.busy), 32'(busy_res));
                    check_field("done_res", 32'(exp_res.done), 32'(done_res));
                    check_field("presence_fail", 32'(exp_res.presence_fail),
                                32'(presence_fail));
                    check_field("rx_byte", 32'(exp_res.rx_byte), 32'(rx_byte));
                    results_checked++;
                end
            end
            if (cfg_we)
            begin
                case (cfg_index)
                    REG_RESET_LOW:    timing.reset_low_us        = cfg_data[9:0];
                    REG_RESET_REL:    timing.reset_release_us    = cfg_data[7:0];
                    REG_PRES_WAIT:    timing.presence_wait_us    = cfg_data[7:0];
                    REG_PRES_LOW_MAX: timing.presence_low_max_us = cfg_data[8:0];
                    REG_WR1_LOW:      timing.write_one_low_us    = cfg_data[5:0];
                    REG_WR0_LOW:      timing.write_zero_low_us   = cfg_data[6:0];
                    REG_RD_LOW:       timing.read_low_us         = cfg_data[5:0];
                    REG_RD_RECOVER:   timing.read_recover_us     = cfg_data[6:0];
                    default:          timing                     = timing;
                endcase
            end
            if (in_valid && !in_stall)
                expected_ticks.push_back(next_result(mode, tx_byte, line_level));
            outstanding <= expected_ticks.size();
            seq_active <= (seq != SEQ_IDLE);
        end
    end

endmodule

`default_nettype wire

>>> dv/one_wire_bus_master_tb.sv
// ----------------------------------------------------------------------------
// one_wire_bus_master_tb
// Drives microsecond ticks into the 1-Wire bus master under reset-default,
// zero, widest and random slot timings; the bus answers resets with presence
// pulses of random length, silence or noise. Results are checked by owm_checker.
// ----------------------------------------------------------------------------
`default_nettype none

module one_wire_bus_master_tb;
    timeunit 1ns;
    timeprecision 1ps;
    import owm_pkg::*;

    localparam int LIMIT        = 400000;
    localparam int HOLD_CYCLES  = 60;
    localparam int DRAIN_CYCLES = 6;
    localparam int PHASE_TICKS  = 30;
    localparam int PHASES       = 3;
    localparam int PULSE_CAP    = 20;

    // how the bus answers a reset
    localparam int LINE_NORMAL = 0;
    localparam int LINE_ABSENT = 1;
    localparam int LINE_NOISE  = 2;
    localparam int LINE_ANY    = 3;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  in_valid = 1'b0;
    logic                  in_stall;
    logic [1:0]            mode = MODE_TICK;
    logic [7:0]            tx_byte = '0;
    logic                  line_level = 1'b1;
    logic                  out_valid;
    logic                  out_stall = 1'b0;
    logic                  drive_low;
    logic                  busy_res;
    logic                  done_res;
    logic                  presence_fail;
    logic [7:0]            rx_byte;
    logic                  cfg_we = 1'b0;
    logic [2:0]            cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data = '0;

    int mismatches, outstanding, results_checked;
    int presence_seen, presence_failed, bytes_written, bytes_read;
    bit seq_active;

    bit   gaps_on = 1'b1;
    bit   rx_quiet = 1'b0;
    bit   rx_hold_req = 1'b0;
    int   ticks_sent = 0;
    int   settings = 1;
    int   cycles = 0;
    cfg_t stim_cfg = '{RST_RESET_LOW, RST_RESET_REL, RST_PRES_WAIT, RST_PRES_LOW_MAX,
                       RST_WR1_LOW, RST_WR0_LOW, RST_RD_LOW, RST_RD_RECOVER};

    one_wire_bus_master dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .mode          (mode),
        .tx_byte       (tx_byte),
        .line_level    (line_level),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .drive_low     (drive_low),
        .busy_res      (busy_res),
        .done_res      (done_res),
        .presence_fail (presence_fail),
        .rx_byte       (rx_byte),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    owm_checker check (
        .clk             (clk),
        .rst_n           (rst_n),
        .in_valid        (in_valid),
        .in_stall        (in_stall),
        .mode            (mode),
        .tx_byte         (tx_byte),
        .line_level      (line_level),
        .out_valid       (out_valid),
        .out_stall       (out_stall),
        .drive_low       (drive_low),
        .busy_res        (busy_res),
        .done_res        (done_res),
        .presence_fail   (presence_fail),
        .rx_byte         (rx_byte),
        .cfg_we          (cfg_we),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data),
        .mismatches      (mismatches),
        .outstanding     (outstanding),
        .seq_active      (seq_active),
        .results_checked (results_checked),
        .presence_seen   (presence_seen),
        .presence_failed (presence_failed),
        .bytes_written   (bytes_written),
        .bytes_read      (bytes_read)
    );

    initial
    begin
        forever #6 clk = ~clk;
    end

    initial
    begin
        while (cycles < LIMIT)
        begin
            @(posedge clk);
            cycles++;
        end
        $display("timeout after %0d cycles, %0d results still expected", cycles, outstanding);
        $display("RESULT: ERROR");
        $finish;
    end

    // result side: random stalls, a quiet stretch and one long hold-off
    initial
    begin
        forever
        begin
            @(posedge clk);
            if (rx_hold_req)
            begin
                out_stall <= 1'b1;
                repeat (HOLD_CYCLES) @(posedge clk);
                out_stall <= 1'b0;
                rx_hold_req = 1'b0;
            end
            else if (rx_quiet)
                out_stall <= 1'b0;
            else
                out_stall <= ($urandom_range(99) < 36);
        end
    end

    function automatic int min_one(int d);
        return (d == 0) ? 1 : d;
    endfunction

    // tick-level bus level seen by the master during a command
    function automatic logic bus_level(logic [1:0] m, int style, int k, int watch0,
                                       int hi_len, int lo_len);
        if (m != MODE_RESET || style == LINE_NOISE)
            return 1'($urandom);
        if (k < min_one(int'(stim_cfg.reset_low_us)))
            return 1'b0;
        if (style == LINE_ABSENT || k < watch0 + hi_len)
            return 1'b1;
        return (k >= watch0 + hi_len + lo_len);
    endfunction

    task automatic send_tick(input logic [1:0] m, input logic [7:0] tx, input logic ln);
        if (gaps_on && $urandom_range(99) < 36)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(2, 1)) @(posedge clk);
        end
        in_valid <= 1'b1;
        mode <= m;
        tx_byte <= tx;
        line_level <= ln;
        do
            @(posedge clk);
        while (in_stall);
        ticks_sent++;
    endtask

    // issue one command and tick it through; stray commands are ignored while busy
    task automatic run_cmd(input logic [1:0] m, input logic [7:0] tx, input int style);
        int         k;
        int         st;
        int         watch0;
        int         hi_len;
        int         lo_len;
        int         r;
        logic [1:0] fm;
        st = style;
        if (style == LINE_ANY)
        begin
            r = $urandom_range(99);
            st = (r < 60) ? LINE_NORMAL : (r < 75) ? LINE_ABSENT : LINE_NOISE;
        end
        watch0 = min_one(int'(stim_cfg.reset_low_us)) + int'(stim_cfg.reset_release_us);
        // presence pulses stay short so that long limits do not stretch the run
        hi_len = int'(stim_cfg.presence_wait_us) + 1;
        lo_len = int'(stim_cfg.presence_low_max_us) + 2;
        hi_len = $urandom_range((hi_len < PULSE_CAP) ? hi_len : PULSE_CAP);
        lo_len = $urandom_range((lo_len < PULSE_CAP) ? lo_len : PULSE_CAP, 1);
        k = 0;
        send_tick(m, tx, bus_level(m, st, k, watch0, hi_len, lo_len));
        // checker status trails by one item, so at least two ticks follow
        do
        begin
            k++;
            fm = ($urandom_range(99) < 15) ? 2'($urandom_range(3, 1)) : MODE_TICK;
            send_tick(fm, 8'($urandom), bus_level(m, st, k, watch0, hi_len, lo_len));
        end
        while (k < 2 || seq_active);
    endtask

    // stop offering items once the sequencer is idle and every result is back
    task automatic settle();
        in_valid <= 1'b0;
        @(posedge clk);
        while (seq_active)
        begin
            send_tick(MODE_TICK, 8'($urandom), 1'($urandom));
            in_valid <= 1'b0;
            @(posedge clk);
        end
        while (outstanding != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input logic [2:0] idx, input logic [CFG_DATA_W-1:0] d);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= d;
        @(posedge clk);
    endtask

    task automatic apply_timing(input cfg_t c);
        settle();
        write_reg(REG_RESET_LOW, c.reset_low_us);
        write_reg(REG_RESET_REL, CFG_DATA_W'(c.reset_release_us));
        write_reg(REG_PRES_WAIT, CFG_DATA_W'(c.presence_wait_us));
        write_reg(REG_PRES_LOW_MAX, CFG_DATA_W'(c.presence_low_max_us));
        write_reg(REG_WR1_LOW, CFG_DATA_W'(c.write_one_low_us));
        write_reg(REG_WR0_LOW, CFG_DATA_W'(c.write_zero_low_us));
        write_reg(REG_RD_LOW, CFG_DATA_W'(c.read_low_us));
        write_reg(REG_RD_RECOVER, CFG_DATA_W'(c.read_recover_us));
        cfg_we <= 1'b0;
        stim_cfg = c;
        settings++;
    endtask

    // mostly short timings, with zero and one now and then
    function automatic int pick_len(int typical);
        int r;
        r = $urandom_range(99);
        if (r < 10)
            return 0;
        if (r < 20)
            return 1;
        return $urandom_range(typical, 1);
    endfunction

    // few ones: every one bit costs a long released time
    function automatic logic [7:0] pick_byte();
        int r;
        r = $urandom_range(99);
        if (r < 30)
            return 8'h00;
        if (r < 85)
            return 8'h01 << $urandom_range(7);
        return 8'($urandom);
    endfunction

    initial
    begin
        cfg_t       c;
        int         start;
        logic [1:0] m;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;

        // presence timing and write-one low time as they come out of reset;
        // only the reset low and write-zero low are cut short
        settle();
        write_reg(REG_RESET_LOW, CFG_DATA_W'(2));
        write_reg(REG_WR0_LOW, CFG_DATA_W'(1));
        cfg_we <= 1'b0;
        stim_cfg.reset_low_us = 10'd2;
        stim_cfg.write_zero_low_us = 7'd1;
        run_cmd(MODE_RESET, 8'h00, LINE_NORMAL);
        run_cmd(MODE_WRITE, 8'h01, LINE_NOISE);

        // all zero: one-tick low times, no reset release, presence fails on first watch
        apply_timing('0);
        run_cmd(MODE_RESET, 8'h00, LINE_NORMAL);
        run_cmd(MODE_WRITE, 8'h00, LINE_NOISE);
        run_cmd(MODE_WRITE, 8'h80, LINE_NOISE);
        run_cmd(MODE_READ, 8'h00, LINE_NOISE);

        // zero presence limit: any low fails at once; absent bus times out
        c = '0;
        c.reset_low_us = 10'd1;
        c.presence_wait_us = 8'd3;
        apply_timing(c);
        run_cmd(MODE_RESET, 8'h00, LINE_NORMAL);
        run_cmd(MODE_RESET, 8'h00, LINE_ABSENT);
        c.presence_low_max_us = 9'd1;
        c.reset_release_us = 8'd2;
        apply_timing(c);
        run_cmd(MODE_RESET, 8'h00, LINE_NORMAL);

        // widest presence limits with a short pulse
        apply_timing('{10'd3, 8'd1, 8'd255, 9'd511, 6'd63, 7'd1, 6'd1, 7'd127});
        run_cmd(MODE_RESET, 8'h00, LINE_NORMAL);

        for (int p = 0; p < PHASES; p++)
        begin
            c.reset_low_us        = 10'(pick_len(12));
            c.reset_release_us    = 8'(pick_len(6));
            c.presence_wait_us    = 8'(pick_len(12));
            c.presence_low_max_us = 9'(pick_len(12));
            c.write_one_low_us    = 6'(pick_len(4));
            c.write_zero_low_us   = 7'(pick_len(4));
            c.read_low_us         = 6'(pick_len(4));
            c.read_recover_us     = 7'(pick_len(4));
            apply_timing(c);
            gaps_on = (p != 1);
            rx_quiet = (p == 1);
            if (p == 2)
                rx_hold_req = 1'b1;
            start = ticks_sent;
            while (ticks_sent - start < PHASE_TICKS)
            begin
                m = 2'($urandom_range(3, 1));
                run_cmd(m, pick_byte(), LINE_ANY);
            end
        end
        gaps_on = 1'b1;
        rx_quiet = 1'b0;
        settle();

        $display("Ran %0d ticks, %0d results checked, over %0d timing settings",
                 ticks_sent, results_checked, settings);
        $display("Resets with presence %0d, failed %0d; bytes written %0d, read %0d",
                 presence_seen, presence_failed, bytes_written, bytes_read);
        if (mismatches == 0 && outstanding == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule

`default_nettype wire

>>> one_wire_bus_master.f
rtl/owm_pkg.sv
rtl/owm_core.sv
rtl/one_wire_bus_master.sv
dv/owm_checker.sv
dv/one_wire_bus_master_tb.sv
